FILE: rtl/pwr_pkg.sv
// Shared types, constants and helpers for the padding window rescale block.
package pwr_pkg;

    localparam int unsigned DefDilationRows = 1;
    localparam int unsigned DefDilationCols = 1;
    localparam int unsigned DefMeanScale    = 0;

    localparam int unsigned AddrW    = 5;
    localparam int unsigned DataW    = 32;
    localparam int unsigned NumW     = 48;
    localparam int unsigned DivSteps = 32;

    localparam logic [31:0] SatMax = 32'h7FFF_FFFF;
    localparam logic [31:0] SatMin = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_KERNEL_HEIGHT = 3'd0,
        REG_KERNEL_WIDTH  = 3'd1,
        REG_STRIDE_ROWS   = 3'd2,
        REG_STRIDE_COLS   = 3'd3,
        REG_PAD_ROWS      = 3'd4,
        REG_PAD_COLS      = 3'd5,
        REG_IMAGE_HEIGHT  = 3'd6,
        REG_IMAGE_WIDTH   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  kernel_height;
        logic [7:0]  kernel_width;
        logic [7:0]  stride_rows;
        logic [7:0]  stride_cols;
        logic [7:0]  pad_rows;
        logic [7:0]  pad_cols;
        logic [12:0] image_height;
        logic [12:0] image_width;
    } pwr_cfg_t;

    typedef struct packed {
        logic [11:0]        out_row;
        logic [11:0]        out_col;
        logic signed [31:0] pixel_value;
    } pwr_in_t;

    typedef struct packed {
        logic signed [31:0] scaled_value;
        logic               empty_window;
    } pwr_out_t;

    // Scaled numerator and tap count handed from the window stages to the divider
    typedef struct packed {
        logic signed [NumW-1:0] num;
        logic [15:0]            taps_in;
        logic [31:0]            pixel;
    } pwr_prod_t;

    // Exact x / d for x below 256 and d up to 16, with recip = ceil(65536 / d)
    function automatic logic [7:0] dil_div(input logic [7:0] x, input logic [16:0] recip);
        logic [24:0] prod;
        prod = {17'd0, x} * {8'd0, recip};
        return prod[23:16];
    endfunction

endpackage

FILE: rtl/padding_window_rescale_top.sv
// Top level: configuration port, window pipeline, divider and output buffer.
//
// One item per cycle in and out while results are taken. From acceptance to
// result: five stages place, clip and count the window and form the numerator,
// one stage prepares the magnitude, 32 divider stages each settle one quotient
// bit, and the last stage is the output register. The whole pipeline holds
// while the output buffer is full; a second output entry keeps item_ready a
// registered signal, so an item is still taken while a result waits.
module padding_window_rescale_top
    import pwr_pkg::*;
#(
    parameter int unsigned DILATION_ROWS = DefDilationRows,
    parameter int unsigned DILATION_COLS = DefDilationCols,
    parameter int unsigned MEAN_SCALE    = DefMeanScale
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    input  logic             item_valid,
    output logic             item_ready,
    input  pwr_in_t          item,
    output logic             result_valid,
    input  logic             result_ready,
    output pwr_out_t         result
);

    pwr_cfg_t  cfg;
    logic      adv;
    logic      geom_valid;
    pwr_prod_t geom_prod;
    logic      div_valid;
    pwr_out_t  div_result;
    logic      incoming;

    logic      out_valid_reg, out_valid_next;
    pwr_out_t  out_reg, out_next;
    logic      skid_valid_reg, skid_valid_next;
    pwr_out_t  skid_reg, skid_next;

    pwr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwr_geom #(
        .DILATION_ROWS (DILATION_ROWS),
        .DILATION_COLS (DILATION_COLS),
        .MEAN_SCALE    (MEAN_SCALE)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (item_valid),
        .item      (item),
        .cfg       (cfg),
        .out_valid (geom_valid),
        .prod      (geom_prod)
    );

    pwr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (geom_valid),
        .prod      (geom_prod),
        .out_valid (div_valid),
        .result    (div_result)
    );

    // advance the pipeline whenever the spare output entry is free
    assign adv        = !skid_valid_reg;
    assign item_ready = adv;
    assign incoming   = adv && div_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || result_ready)
        begin
            out_valid_next  = skid_valid_reg || incoming;
            out_next        = skid_valid_reg ? skid_reg : div_result;
            skid_valid_next = 1'b0;
        end
        else if (incoming)
        begin
            // output held: park the arriving item
            skid_valid_next = 1'b1;
            skid_next       = div_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("spare entry holds an item while the output is empty");
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result_ready))
        else $error("spare entry filled while the output was free");
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_valid_reg) |-> $past(result_ready))
        else $error("spare entry drained without the output being taken");
`endif

endmodule

FILE: rtl/pwr_cfg.sv
// Configuration register file behind the APB-style port.
module pwr_cfg
    import pwr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output pwr_cfg_t         cfg
);

    pwr_cfg_t cfg_reg;
    pwr_cfg_t cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_KERNEL_HEIGHT: cfg_next.kernel_height = pwdata[7:0];
                REG_KERNEL_WIDTH:  cfg_next.kernel_width  = pwdata[7:0];
                REG_STRIDE_ROWS:   cfg_next.stride_rows   = pwdata[7:0];
                REG_STRIDE_COLS:   cfg_next.stride_cols   = pwdata[7:0];
                REG_PAD_ROWS:      cfg_next.pad_rows      = pwdata[7:0];
                REG_PAD_COLS:      cfg_next.pad_cols      = pwdata[7:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = pwdata[12:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = pwdata[12:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KERNEL_HEIGHT: prdata = {24'd0, cfg_reg.kernel_height};
            REG_KERNEL_WIDTH:  prdata = {24'd0, cfg_reg.kernel_width};
            REG_STRIDE_ROWS:   prdata = {24'd0, cfg_reg.stride_rows};
            REG_STRIDE_COLS:   prdata = {24'd0, cfg_reg.stride_cols};
            REG_PAD_ROWS:      prdata = {24'd0, cfg_reg.pad_rows};
            REG_PAD_COLS:      prdata = {24'd0, cfg_reg.pad_cols};
            REG_IMAGE_HEIGHT:  prdata = {19'd0, cfg_reg.image_height};
            REG_IMAGE_WIDTH:   prdata = {19'd0, cfg_reg.image_width};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_height <= 8'd3;
            cfg_reg.kernel_width  <= 8'd3;
            cfg_reg.stride_rows   <= 8'd1;
            cfg_reg.stride_cols   <= 8'd1;
            cfg_reg.pad_rows      <= 8'd1;
            cfg_reg.pad_cols      <= 8'd1;
            cfg_reg.image_height  <= 13'd64;
            cfg_reg.image_width   <= 13'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/pwr_geom.sv
// Window placement, clipping, tap counting and numerator product: five stages.
module pwr_geom
    import pwr_pkg::*;
#(
    parameter int unsigned DILATION_ROWS = DefDilationRows,
    parameter int unsigned DILATION_COLS = DefDilationCols,
    parameter int unsigned MEAN_SCALE    = DefMeanScale
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  pwr_in_t   item,
    input  pwr_cfg_t  cfg,
    output logic      out_valid,
    output pwr_prod_t prod
);

    localparam logic [16:0] RecipRows = 17'((65536 + DILATION_ROWS - 1) / DILATION_ROWS);
    localparam logic [16:0] RecipCols = 17'((65536 + DILATION_COLS - 1) / DILATION_COLS);

    // stage 1: window start
    logic               v1_reg;
    logic [19:0]        row_prod;
    logic [19:0]        col_prod;
    logic signed [21:0] row_start1_reg, row_start1_next;
    logic signed [21:0] col_start1_reg, col_start1_next;
    logic [31:0]        pix1_reg;
    // stage 2: window end, start clipped to the image
    logic               v2_reg;
    logic signed [21:0] row_start2_reg, row_start2_next;
    logic signed [21:0] row_end2_reg, row_end2_next;
    logic signed [21:0] col_start2_reg, col_start2_next;
    logic signed [21:0] col_end2_reg, col_end2_next;
    logic [31:0]        pix2_reg;
    // stage 3: extent inside the image
    logic               v3_reg;
    logic signed [21:0] row_end3;
    logic signed [21:0] col_end3;
    logic signed [21:0] row_len;
    logic signed [21:0] col_len;
    logic               row_pos3_reg, row_pos3_next;
    logic               col_pos3_reg, col_pos3_next;
    logic [7:0]         row_lm3_reg, row_lm3_next;
    logic [7:0]         col_lm3_reg, col_lm3_next;
    logic [31:0]        pix3_reg;
    // stage 4: dilated tap counts
    logic               v4_reg;
    logic [7:0]         hin4_reg, hin4_next;
    logic [7:0]         win4_reg, win4_next;
    logic [31:0]        pix4_reg;
    // stage 5: inside count and scaled numerator
    logic               v5_reg;
    pwr_prod_t          prod5_reg, prod5_next;
    logic signed [48:0] mul_full;
    // full window taps, follow the registers
    logic [7:0]         fh_reg, fh_next;
    logic [7:0]         fw_reg, fw_next;
    logic [15:0]        full_reg, full_next;

    always_comb
    begin
        row_prod        = {8'd0, item.out_row} * {12'd0, cfg.stride_rows};
        col_prod        = {8'd0, item.out_col} * {12'd0, cfg.stride_cols};
        row_start1_next = $signed({2'b00, row_prod}) - $signed({14'd0, cfg.pad_rows});
        col_start1_next = $signed({2'b00, col_prod}) - $signed({14'd0, cfg.pad_cols});
    end

    // The cap at size plus pad never binds below the image edge, so clip to size only
    always_comb
    begin
        row_end2_next   = row_start1_reg + $signed({14'd0, cfg.kernel_height});
        col_end2_next   = col_start1_reg + $signed({14'd0, cfg.kernel_width});
        row_start2_next = row_start1_reg[21] ? 22'sd0 : row_start1_reg;
        col_start2_next = col_start1_reg[21] ? 22'sd0 : col_start1_reg;
    end

    always_comb
    begin
        row_end3 = row_end2_reg;
        if (row_end2_reg > $signed({9'd0, cfg.image_height}))
        begin
            row_end3 = $signed({9'd0, cfg.image_height});
        end
        col_end3 = col_end2_reg;
        if (col_end2_reg > $signed({9'd0, cfg.image_width}))
        begin
            col_end3 = $signed({9'd0, cfg.image_width});
        end
        row_len       = row_end3 - row_start2_reg;
        col_len       = col_end3 - col_start2_reg;
        row_pos3_next = !row_len[21] && (row_len != 22'sd0);
        col_pos3_next = !col_len[21] && (col_len != 22'sd0);
        // extent never exceeds the kernel size, so eight bits hold it
        row_lm3_next  = row_len[7:0] - 8'd1;
        col_lm3_next  = col_len[7:0] - 8'd1;
    end

    always_comb
    begin
        hin4_next = row_pos3_reg ? dil_div(row_lm3_reg, RecipRows) + 8'd1 : 8'd0;
        win4_next = col_pos3_reg ? dil_div(col_lm3_reg, RecipCols) + 8'd1 : 8'd0;
        fh_next   = (cfg.kernel_height == 8'd0) ? 8'd0 :
                    dil_div(cfg.kernel_height - 8'd1, RecipRows) + 8'd1;
        fw_next   = (cfg.kernel_width == 8'd0) ? 8'd0 :
                    dil_div(cfg.kernel_width - 8'd1, RecipCols) + 8'd1;
        full_next = {8'd0, fh_reg} * {8'd0, fw_reg};
    end

    always_comb
    begin
        mul_full           = $signed(pix4_reg) * $signed({1'b0, full_reg});
        prod5_next.taps_in = {8'd0, hin4_reg} * {8'd0, win4_reg};
        prod5_next.pixel   = pix4_reg;
        if (MEAN_SCALE != 0)
        begin
            prod5_next.num = $signed({{(NumW - 32){pix4_reg[31]}}, pix4_reg});
        end
        else
        begin
            prod5_next.num = mul_full[NumW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fh_reg   <= fh_next;
        fw_reg   <= fw_next;
        full_reg <= full_next;
        if (adv)
        begin
            row_start1_reg <= row_start1_next;
            col_start1_reg <= col_start1_next;
            pix1_reg       <= item.pixel_value;
            row_start2_reg <= row_start2_next;
            row_end2_reg   <= row_end2_next;
            col_start2_reg <= col_start2_next;
            col_end2_reg   <= col_end2_next;
            pix2_reg       <= pix1_reg;
            row_pos3_reg   <= row_pos3_next;
            col_pos3_reg   <= col_pos3_next;
            row_lm3_reg    <= row_lm3_next;
            col_lm3_reg    <= col_lm3_next;
            pix3_reg       <= pix2_reg;
            hin4_reg       <= hin4_next;
            win4_reg       <= win4_next;
            pix4_reg       <= pix3_reg;
            prod5_reg      <= prod5_next;
        end
    end

    assign out_valid = v5_reg;
    assign prod      = prod5_reg;

endmodule

FILE: rtl/pwr_div.sv
// Pipelined signed divide by the inside tap count, one quotient bit per stage, with saturation.
module pwr_div
    import pwr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  pwr_prod_t prod,
    output logic      out_valid,
    output pwr_out_t  result
);

    logic [NumW-1:0] num_u;
    logic [NumW-1:0] mag;
    logic            neg_next;
    logic            ovf_next;

    logic        valid_reg [0:DivSteps];
    logic [15:0] rem_reg   [0:DivSteps];
    logic [31:0] quo_reg   [0:DivSteps];
    logic [15:0] taps_reg  [0:DivSteps];
    logic        neg_reg   [0:DivSteps];
    logic        ovf_reg   [0:DivSteps];
    logic        empty_reg [0:DivSteps];
    logic [31:0] pix_reg   [0:DivSteps];

    logic [31:0] q_last;

    // prepare magnitude; a quotient of 2^32 or more saturates without dividing
    always_comb
    begin
        num_u    = prod.num;
        neg_next = num_u[NumW-1];
        mag      = neg_next ? (~num_u + {{(NumW - 1){1'b0}}, 1'b1}) : num_u;
        ovf_next = (mag[NumW-1:32] >= prod.taps_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]   <= mag[NumW-1:32];
            quo_reg[0]   <= mag[31:0];
            taps_reg[0]  <= prod.taps_in;
            neg_reg[0]   <= neg_next;
            ovf_reg[0]   <= ovf_next;
            empty_reg[0] <= (prod.taps_in == 16'd0);
            pix_reg[0]   <= prod.pixel;
        end
    end

    for (genvar k = 1; k <= DivSteps; k++)
    begin : g_step
        logic [16:0] trial;
        logic [16:0] diff;
        logic [15:0] rem_next;
        logic [31:0] quo_next;

        always_comb
        begin
            trial = {rem_reg[k-1], quo_reg[k-1][31]};
            diff  = trial - {1'b0, taps_reg[k-1]};
            if (trial >= {1'b0, taps_reg[k-1]})
            begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[k-1][30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[k-1][30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]   <= rem_next;
                quo_reg[k]   <= quo_next;
                taps_reg[k]  <= taps_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                ovf_reg[k]   <= ovf_reg[k-1];
                empty_reg[k] <= empty_reg[k-1];
                pix_reg[k]   <= pix_reg[k-1];
            end
        end
    end

    // pass the pixel through for an empty window, else restore sign and clamp to the 32-bit range
    always_comb
    begin
        q_last = quo_reg[DivSteps];
        result.empty_window = 1'b0;
        if (empty_reg[DivSteps])
        begin
            result.scaled_value = pix_reg[DivSteps];
            result.empty_window = 1'b1;
        end
        else if (ovf_reg[DivSteps])
        begin
            result.scaled_value = neg_reg[DivSteps] ? SatMin : SatMax;
        end
        else if (neg_reg[DivSteps])
        begin
            result.scaled_value = (q_last > SatMin) ? SatMin : (~q_last + 32'd1);
        end
        else
        begin
            result.scaled_value = q_last[31] ? SatMax : q_last;
        end
    end

    assign out_valid = valid_reg[DivSteps];

`ifndef SYNTHESIS
    a_rem_start: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !empty_reg[0] && !ovf_reg[0]) |-> (rem_reg[0] < taps_reg[0]))
        else $error("divider remainder starts at or above the divisor");
    a_rem_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[DivSteps] && !empty_reg[DivSteps])
            |-> (rem_reg[DivSteps] < taps_reg[DivSteps]) || ovf_reg[DivSteps])
        else $error("divider remainder ends at or above the divisor");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[DivSteps] && !empty_reg[DivSteps] && ovf_reg[DivSteps])
            |-> (result.scaled_value == SatMax) || (result.scaled_value == SatMin))
        else $error("overflowed quotient not saturated");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the padding window rescale block.
module tb_top
    import pwr_pkg::*;
;

    localparam int unsigned DilRows = DefDilationRows;
    localparam int unsigned DilCols = DefDilationCols;
    localparam int unsigned AvgMode = DefMeanScale;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [AddrW-1:0] paddr   = '0;
    logic [DataW-1:0] pwdata  = '0;
    logic [DataW-1:0] prdata;
    logic             pready;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    pwr_in_t          item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    pwr_out_t         result;

    pwr_cfg_t win_cfg;
    pwr_in_t  pending_items[$];
    pwr_out_t rescale_expect[$];
    int       mismatches   = 0;
    int       gap_left     = 0;
    int       stall_left   = 0;
    logic     idle_on      = 1'b1;
    logic     hold_results = 1'b0;
    logic     sender_hold  = 1'b0;

    padding_window_rescale_top #(
        .DILATION_ROWS(DilRows),
        .DILATION_COLS(DilCols),
        .MEAN_SCALE   (AvgMode)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always #10 clk = ~clk;

    function automatic longint span_taps(input longint len, input longint dil);
        if (len <= 0)
            return 0;
        return (len - 1) / dil + 1;
    endfunction

    // Taps of the clipped window along one axis
    function automatic longint axis_taps(input longint idx, input longint stride,
                                         input longint pad, input longint ksize,
                                         input longint isize, input longint dil);
        longint win_lo;
        longint win_hi;
        win_lo = idx * stride - pad;
        win_hi = win_lo + ksize;
        if (win_hi > isize + pad)
            win_hi = isize + pad;
        if (win_lo < 0)
            win_lo = 0;
        if (win_hi > isize)
            win_hi = isize;
        return span_taps(win_hi - win_lo, dil);
    endfunction

    function automatic pwr_out_t rescale_predict(input pwr_in_t it);
        pwr_out_t r;
        longint   v;
        longint   taps_in;
        longint   full;
        longint   q;
        taps_in = axis_taps(it.out_row, win_cfg.stride_rows, win_cfg.pad_rows,
                            win_cfg.kernel_height, win_cfg.image_height, DilRows)
                * axis_taps(it.out_col, win_cfg.stride_cols, win_cfg.pad_cols,
                            win_cfg.kernel_width, win_cfg.image_width, DilCols);
        if (taps_in == 0)
        begin
            r.scaled_value = it.pixel_value;
            r.empty_window = 1'b1;
            return r;
        end
        v = longint'($signed(it.pixel_value));
        if (AvgMode != 0)
            q = v / taps_in;
        else
        begin
            full = span_taps(win_cfg.kernel_height, DilRows)
                 * span_taps(win_cfg.kernel_width, DilCols);
            q = (v * full) / taps_in;
        end
        if (q > longint'($signed(SatMax)))
            q = longint'($signed(SatMax));
        if (q < longint'($signed(SatMin)))
            q = longint'($signed(SatMin));
        r.scaled_value = q[31:0];
        r.empty_window = 1'b0;
        return r;
    endfunction

    // Present the next pending item; hold valid and payload until taken
    always @(posedge clk)
    begin : item_driver
        logic offering;
        offering = item_valid;
        if (item_valid && item_ready)
        begin
            rescale_expect.push_back(rescale_predict(item));
            offering = 1'b0;
            gap_left = idle_on ? $urandom_range(0, 10) : 0;
        end
        if (!offering)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() != 0 && !sender_hold)
            begin
                item <= pending_items.pop_front();
                offering = 1'b1;
            end
        end
        item_valid <= offering;
    end

    always @(posedge clk)
    begin : result_monitor
        pwr_out_t want;
        if (result_valid && result_ready)
        begin
            if (rescale_expect.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected: expected none, actual %h",
                         $time, result);
            end
            else
            begin
                want = rescale_expect.pop_front();
                if (result.scaled_value !== want.scaled_value)
                begin
                    mismatches++;
                    $display("%0t: scaled_value expected %h actual %h",
                             $time, want.scaled_value, result.scaled_value);
                end
                if (result.empty_window !== want.empty_window)
                begin
                    mismatches++;
                    $display("%0t: empty_window expected %b actual %b",
                             $time, want.empty_window, result.empty_window);
                end
            end
            stall_left = idle_on ? $urandom_range(0, 10) : 0;
        end
        else if (stall_left > 0)
            stall_left--;
        result_ready <= !hold_results && stall_left == 0;
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KERNEL_HEIGHT: win_cfg.kernel_height = val[7:0];
            REG_KERNEL_WIDTH:  win_cfg.kernel_width  = val[7:0];
            REG_STRIDE_ROWS:   win_cfg.stride_rows   = val[7:0];
            REG_STRIDE_COLS:   win_cfg.stride_cols   = val[7:0];
            REG_PAD_ROWS:      win_cfg.pad_rows      = val[7:0];
            REG_PAD_COLS:      win_cfg.pad_cols      = val[7:0];
            REG_IMAGE_HEIGHT:  win_cfg.image_height  = val[12:0];
            REG_IMAGE_WIDTH:   win_cfg.image_width   = val[12:0];
            default: ;
        endcase
    endtask

    task automatic set_shape(input int kh, input int kw, input int sr, input int sc,
                             input int pr, input int pc, input int ih, input int iw);
        write_reg(REG_KERNEL_HEIGHT, kh);
        write_reg(REG_KERNEL_WIDTH, kw);
        write_reg(REG_STRIDE_ROWS, sr);
        write_reg(REG_STRIDE_COLS, sc);
        write_reg(REG_PAD_ROWS, pr);
        write_reg(REG_PAD_COLS, pc);
        write_reg(REG_IMAGE_HEIGHT, ih);
        write_reg(REG_IMAGE_WIDTH, iw);
    endtask

    task automatic random_shape();
        int kh;
        int kw;
        kh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 7);
        kw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 7);
        set_shape(kh, kw,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, kh),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, kw),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 48),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 48));
    endtask

    function automatic pwr_in_t make_item(input int r, input int c, input logic [31:0] p);
        pwr_in_t it;
        it.out_row     = r[11:0];
        it.out_col     = c[11:0];
        it.pixel_value = p;
        return it;
    endfunction

    // Favour indices whose windows touch the image, and its edges in particular
    function automatic int pick_index(input int stride, input int pad, input int isize);
        int lim;
        if (stride == 0)
            stride = 1;
        lim = (isize + 2 * pad) / stride + 2;
        if (lim > 4095)
            lim = 4095;
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 4095);
            1:       return $urandom_range(0, (lim < 3) ? lim : 3);
            2:       return $urandom_range((lim < 3) ? 0 : lim - 3, lim);
            default: return $urandom_range(0, lim);
        endcase
    endfunction

    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1:       return 32'h8000_0000 + $urandom_range(0, 3);
            2:       return $urandom_range(0, 16'hFFFF) << 16;
            3:       return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF);
            default: return $urandom();
        endcase
    endfunction

    task automatic fill_random(input int n);
        repeat (n)
            pending_items.push_back(make_item(
                pick_index(win_cfg.stride_rows, win_cfg.pad_rows, win_cfg.image_height),
                pick_index(win_cfg.stride_cols, win_cfg.pad_cols, win_cfg.image_width),
                pick_pixel()));
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pending_items.size() != 0 || item_valid || rescale_expect.size() != 0);
    endtask

    initial
    begin
        int p;
        int n;
        win_cfg = '{kernel_height: 8'd3, kernel_width: 8'd3, stride_rows: 8'd1,
                    stride_cols: 8'd1, pad_rows: 8'd1, pad_cols: 8'd1,
                    image_height: 13'd64, image_width: 13'd64};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset shape: corners, far edges, empty windows, value extremes
        pending_items.push_back(make_item(0, 0, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(0, 0, 32'h8000_0000));
        pending_items.push_back(make_item(0, 63, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(63, 0, 32'h0000_0001));
        pending_items.push_back(make_item(1, 1, 32'h1234_5678));
        pending_items.push_back(make_item(64, 64, 32'h0001_0000));
        pending_items.push_back(make_item(65, 3, 32'h0002_0000));
        pending_items.push_back(make_item(3, 65, 32'hFFFE_0000));
        pending_items.push_back(make_item(4095, 4095, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(0, 0, 32'h0000_0000));
        drain();

        // Largest kernel, stride and pad
        set_shape(255, 255, 255, 255, 255, 255, 4096, 4096);
        pending_items.push_back(make_item(0, 0, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(4095, 4095, 32'h8000_0000));
        pending_items.push_back(make_item(1, 0, 32'hFFFF_FFF9));
        drain();

        // Smallest shape: one-pixel image, no padding
        set_shape(1, 1, 1, 1, 0, 0, 1, 1);
        pending_items.push_back(make_item(0, 0, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(0, 1, 32'h0000_0005));
        drain();

        // Zero kernel height: every window is empty
        set_shape(0, 3, 1, 1, 1, 1, 64, 64);
        pending_items.push_back(make_item(0, 0, 32'h0000_0100));
        drain();

        // Zero image height, widest writable image width
        set_shape(3, 3, 1, 1, 1, 1, 0, 8191);
        pending_items.push_back(make_item(0, 0, 32'h0000_0200));
        drain();

        // Zero stride: every window sits at minus the pad
        set_shape(4, 5, 0, 0, 2, 1, 10, 10);
        pending_items.push_back(make_item(4095, 4095, 32'h8000_0000));
        pending_items.push_back(make_item(7, 0, 32'h7FFF_FFFF));
        drain();

        for (p = 0; p < 12; p++)
        begin
            idle_on = (p % 4 != 1);
            random_shape();
            @(negedge clk);
            if (p == 3)
            begin
                // Back-pressure long enough to fill the pipeline and stall input
                idle_on = 1'b0;
                fill_random(300);
                @(posedge clk);
                hold_results <= 1'b1;
                repeat (150) @(posedge clk);
                hold_results <= 1'b0;
            end
            else if (p == 7)
            begin
                n = 120;
                fill_random(n);
                do @(negedge clk); while (pending_items.size() > n / 2);
                @(posedge clk);
                sender_hold <= 1'b1;
                do @(negedge clk); while (item_valid || rescale_expect.size() != 0);
                @(posedge clk);
                sender_hold <= 1'b0;
            end
            else
                fill_random(120);
            drain();
        end

        repeat (60) @(posedge clk);
        if (mismatches == 0 && rescale_expect.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(20 * 700000);
        $display("FAIL");
        $finish;
    end

endmodule
